FILE: sv/lfpd_pkg.sv
// Package for the line follower PID drive unit: widths, register indexes,
// micro-operation and jump codes, control and status structs, and the sensor error table.
// No dependencies.
`default_nettype none

package lfpd_pkg;

   localparam int FRAC_BITS = 8;
   localparam int GAIN_FRAC = 8;
   localparam int SHIFT_W   = GAIN_FRAC + FRAC_BITS;

   localparam int SENS_W  = 5;
   localparam int ERR_W   = 11;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int SUM_W   = 18;
   localparam int SPD_W   = 9;
   localparam int GAIN_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int MUL_A_W = GAIN_W + 1;
   localparam int MUL_B_W = SUM_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int CORR_W  = ACC_W - SHIFT_W;
   localparam int TGT_W   = CORR_W + 1;
   localparam int SLEW_W  = SPD_W + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = GAIN_W;

   localparam logic [CSR_IDX_W-1:0] REG_KP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ILIM  = 3'd6;

   localparam logic [GAIN_W-1:0] KP_RESET    = 16'd17920;
   localparam logic [GAIN_W-1:0] KI_RESET    = 16'd13;
   localparam logic [GAIN_W-1:0] KD_RESET    = 16'd0;
   localparam logic [BYTE_W-1:0] BASE_RESET  = 8'd100;
   localparam logic [BYTE_W-1:0] MAX_RESET   = 8'd180;
   localparam logic [BYTE_W-1:0] ACCEL_RESET = 8'd10;
   localparam logic [BYTE_W-1:0] ILIM_RESET  = 8'd50;

   localparam int STEP_W = 4;
   localparam int OP_W   = 4;
   localparam int COND_W = 3;

   localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
   localparam logic [OP_W-1:0] OP_WAIT   = 4'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 4'd2;
   localparam logic [OP_W-1:0] OP_INTEG  = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL_P  = 4'd4;
   localparam logic [OP_W-1:0] OP_MUL_I  = 4'd5;
   localparam logic [OP_W-1:0] OP_MUL_D  = 4'd6;
   localparam logic [OP_W-1:0] OP_ACC    = 4'd7;
   localparam logic [OP_W-1:0] OP_CORR   = 4'd8;
   localparam logic [OP_W-1:0] OP_TARGET = 4'd9;
   localparam logic [OP_W-1:0] OP_CLAMP  = 4'd10;
   localparam logic [OP_W-1:0] OP_SLEW   = 4'd11;
   localparam logic [OP_W-1:0] OP_CLEAR  = 4'd12;
   localparam logic [OP_W-1:0] OP_EMIT   = 4'd13;

   localparam logic [COND_W-1:0] COND_NONE     = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd2;
   localparam logic [COND_W-1:0] COND_MODE     = 3'd3;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic mode;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      logic [GAIN_W-1:0] kp;
      logic [GAIN_W-1:0] ki;
      logic [GAIN_W-1:0] kd;
      logic [BYTE_W-1:0] base;
      logic [BYTE_W-1:0] max_spd;
      logic [BYTE_W-1:0] accel;
      logic [BYTE_W-1:0] ilim;
   } cfg_type;

   // Weighted sensor sum divided by the active count, Q8, truncated toward zero.
   // The pattern with no active sensor has no meaning here and reads as zero.
   function automatic logic signed [ERR_W-1:0] err_lut(input logic [SENS_W-1:0] bits);
      logic signed [ERR_W-1:0] e;
      case (bits)
         5'd1:    e = -11'sd768;
         5'd2:    e = -11'sd512;
         5'd3:    e = -11'sd640;
         5'd4:    e = 11'sd0;
         5'd5:    e = -11'sd384;
         5'd6:    e = -11'sd256;
         5'd7:    e = -11'sd426;
         5'd8:    e = 11'sd512;
         5'd9:    e = -11'sd128;
         5'd10:   e = 11'sd0;
         5'd11:   e = -11'sd256;
         5'd12:   e = 11'sd256;
         5'd13:   e = -11'sd85;
         5'd14:   e = 11'sd0;
         5'd15:   e = -11'sd192;
         5'd16:   e = 11'sd768;
         5'd17:   e = 11'sd0;
         5'd18:   e = 11'sd128;
         5'd19:   e = -11'sd170;
         5'd20:   e = 11'sd384;
         5'd21:   e = 11'sd0;
         5'd22:   e = 11'sd85;
         5'd23:   e = -11'sd128;
         5'd24:   e = 11'sd640;
         5'd25:   e = 11'sd170;
         5'd26:   e = 11'sd256;
         5'd27:   e = 11'sd0;
         5'd28:   e = 11'sd426;
         5'd29:   e = 11'sd128;
         5'd30:   e = 11'sd192;
         5'd31:   e = 11'sd0;
         default: e = 11'sd0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

FILE: sv/lfpd_seq.sv
// Microcode sequencer: step counter, control-word ROM and conditional jumps.
// Depends on lfpd_pkg.
`default_nettype none

module lfpd_seq
   import lfpd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);

   localparam logic [STEP_W-1:0] S_WAIT   = 4'd0;
   localparam logic [STEP_W-1:0] S_LOOKUP = 4'd1;
   localparam logic [STEP_W-1:0] S_INTEG  = 4'd2;
   localparam logic [STEP_W-1:0] S_MUL_P  = 4'd3;
   localparam logic [STEP_W-1:0] S_MUL_I  = 4'd4;
   localparam logic [STEP_W-1:0] S_MUL_D  = 4'd5;
   localparam logic [STEP_W-1:0] S_ACC    = 4'd6;
   localparam logic [STEP_W-1:0] S_CORR   = 4'd7;
   localparam logic [STEP_W-1:0] S_TARGET = 4'd8;
   localparam logic [STEP_W-1:0] S_CLAMP  = 4'd9;
   localparam logic [STEP_W-1:0] S_SLEW   = 4'd10;
   localparam logic [STEP_W-1:0] S_CLEAR  = 4'd11;
   localparam logic [STEP_W-1:0] S_EMIT   = 4'd12;
   localparam logic [STEP_W-1:0] S_RETURN = 4'd13;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              jump;

   function automatic ctrl_type rom(input logic [STEP_W-1:0] s);
      ctrl_type c;
      case (s)
         S_WAIT:   c = '{op: OP_WAIT,   cond: COND_NO_REQ,   target: S_WAIT};
         S_LOOKUP: c = '{op: OP_LOOKUP, cond: COND_MODE,     target: S_CLEAR};
         S_INTEG:  c = '{op: OP_INTEG,  cond: COND_NONE,     target: S_WAIT};
         S_MUL_P:  c = '{op: OP_MUL_P,  cond: COND_NONE,     target: S_WAIT};
         S_MUL_I:  c = '{op: OP_MUL_I,  cond: COND_NONE,     target: S_WAIT};
         S_MUL_D:  c = '{op: OP_MUL_D,  cond: COND_NONE,     target: S_WAIT};
         S_ACC:    c = '{op: OP_ACC,    cond: COND_NONE,     target: S_WAIT};
         S_CORR:   c = '{op: OP_CORR,   cond: COND_NONE,     target: S_WAIT};
         S_TARGET: c = '{op: OP_TARGET, cond: COND_NONE,     target: S_WAIT};
         S_CLAMP:  c = '{op: OP_CLAMP,  cond: COND_NONE,     target: S_WAIT};
         S_SLEW:   c = '{op: OP_SLEW,   cond: COND_ALWAYS,   target: S_EMIT};
         S_CLEAR:  c = '{op: OP_CLEAR,  cond: COND_NONE,     target: S_WAIT};
         S_EMIT:   c = '{op: OP_EMIT,   cond: COND_OUT_BUSY, target: S_EMIT};
         S_RETURN: c = '{op: OP_NOP,    cond: COND_ALWAYS,   target: S_WAIT};
         default:  c = '{op: OP_NOP,    cond: COND_ALWAYS,   target: S_WAIT};
      endcase
      return c;
   endfunction

   assign ctrl = rom(step_ff);

   always_comb begin
      case (ctrl.cond)
         COND_NONE:     jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = ~req_valid;
         COND_MODE:     jump = stat.mode;
         COND_OUT_BUSY: jump = stat.out_busy;
         default:       jump = 1'b0;
      endcase
      step_in = jump ? ctrl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/lfpd_dp.sv
// Datapath of the drive unit: error lookup, integral, shared multiplier with accumulator,
// wheel clamp and slew limit, and the result register. Driven by the control word.
// Depends on lfpd_pkg.
`default_nettype none

module lfpd_dp
   import lfpd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctrl_type                 ctrl,
   input  wire cfg_type                  cfg,
   output stat_type                      stat,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_mode,
   input  wire logic [SENS_W-1:0]        req_sensor_bits,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [SPD_W-1:0]       rsp_left_speed,
   output logic signed [SPD_W-1:0]       rsp_right_speed,
   output logic signed [ERR_W-1:0]       rsp_position_error,
   output logic                          rsp_line_lost
);

   logic                       mode_ff;
   logic [SENS_W-1:0]          bits_ff;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic                       lost_ff, lost_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [ERR_W-1:0]    prev_err_ff, prev_err_in;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [CORR_W-1:0]   corr_ff;
   logic signed [TGT_W-1:0]    tl_ff, tr_ff;
   logic signed [SPD_W-1:0]    cl_ff, cr_ff;
   logic signed [SPD_W-1:0]    left_ff, left_in, right_ff, right_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SPD_W-1:0]    rsp_left_ff, rsp_right_ff;
   logic signed [ERR_W-1:0]    rsp_err_ff;
   logic                       rsp_lost_ff;

   logic                       accept, out_busy, emit_go;
   logic signed [SUM_W:0]      sum_wide, lim_w;
   logic signed [DIFF_W-1:0]   diff;
   logic [GAIN_W-1:0]          mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic signed [ACC_W-1:0]    acc_sum, corr_sum;
   logic signed [TGT_W-1:0]    base_t, corr_t;

   function automatic logic signed [SPD_W-1:0] clamp_speed(
      input logic signed [TGT_W-1:0] t,
      input logic [BYTE_W-1:0]       m
   );
      logic signed [TGT_W-1:0] mt;
      logic signed [TGT_W-1:0] r;
      mt = $signed({{(TGT_W-BYTE_W){1'b0}}, m});
      if (t > mt) begin
         r = mt;
      end else if (t < -mt) begin
         r = -mt;
      end else begin
         r = t;
      end
      return r[SPD_W-1:0];
   endfunction

   function automatic logic signed [SPD_W-1:0] slew_limit(
      input logic signed [SPD_W-1:0] s,
      input logic signed [SPD_W-1:0] prev,
      input logic [BYTE_W-1:0]       a
   );
      logic signed [SLEW_W-1:0] sx, px, ax, lo, hi, r;
      sx = {s[SPD_W-1], s};
      px = {prev[SPD_W-1], prev};
      ax = $signed({{(SLEW_W-BYTE_W){1'b0}}, a});
      lo = px - ax;
      hi = px + ax;
      if (sx < lo) begin
         r = lo;
      end else if (sx > hi) begin
         r = hi;
      end else begin
         r = sx;
      end
      // The bound lies between the target and the previous value, so it fits.
      return r[SPD_W-1:0];
   endfunction

   assign req_stall = (ctrl.op != OP_WAIT);
   assign accept    = req_valid & ~req_stall;
   assign out_busy  = rsp_valid_ff & rsp_stall;
   assign emit_go   = (ctrl.op == OP_EMIT) & ~out_busy;
   assign stat      = '{mode: mode_ff, out_busy: out_busy};

   // Integral with clamp to plus or minus the limit shifted into Q8.
   assign sum_wide = {sum_ff[SUM_W-1], sum_ff}
                   + {{(SUM_W+1-ERR_W){err_ff[ERR_W-1]}}, err_ff};
   assign lim_w    = $signed({{(SUM_W+1-BYTE_W-FRAC_BITS){1'b0}}, cfg.ilim,
                              {FRAC_BITS{1'b0}}});
   assign diff     = {err_ff[ERR_W-1], err_ff} - {prev_err_ff[ERR_W-1], prev_err_ff};

   always_comb begin
      case (ctrl.op)
         OP_MUL_P: begin
            mul_a = cfg.kp;
            mul_b = {{(MUL_B_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         OP_MUL_I: begin
            mul_a = cfg.ki;
            mul_b = sum_ff;
         end
         OP_MUL_D: begin
            mul_a = cfg.kd;
            mul_b = {{(MUL_B_W-DIFF_W){diff[DIFF_W-1]}}, diff};
         end
         default: begin
            mul_a = cfg.kp;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = $signed({1'b0, mul_a}) * mul_b;
   assign acc_sum = acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   // Adding all ones below the cut makes the arithmetic shift truncate toward zero.
   assign corr_sum = acc_ff + $signed({{(ACC_W-SHIFT_W){1'b0}},
                                       {SHIFT_W{acc_ff[ACC_W-1]}}});
   assign base_t  = $signed({{(TGT_W-BYTE_W){1'b0}}, cfg.base});
   assign corr_t  = {corr_ff[CORR_W-1], corr_ff};

   always_comb begin
      err_in      = err_ff;
      lost_in     = lost_ff;
      sum_in      = sum_ff;
      prev_err_in = prev_err_ff;
      acc_in      = acc_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      case (ctrl.op)
         OP_LOOKUP: begin
            lost_in = (bits_ff == '0);
            err_in  = (bits_ff == '0) ? prev_err_ff : err_lut(bits_ff);
         end
         OP_INTEG: begin
            if (sum_wide > lim_w) begin
               sum_in = lim_w[SUM_W-1:0];
            end else if (sum_wide < -lim_w) begin
               sum_in = -$signed(lim_w[SUM_W-1:0]);
            end else begin
               sum_in = sum_wide[SUM_W-1:0];
            end
         end
         OP_MUL_P: acc_in = '0;
         OP_MUL_I, OP_MUL_D, OP_ACC: acc_in = acc_sum;
         OP_CORR: prev_err_in = err_ff;
         OP_SLEW: begin
            left_in  = slew_limit(cl_ff, left_ff, cfg.accel);
            right_in = slew_limit(cr_ff, right_ff, cfg.accel);
         end
         OP_CLEAR: begin
            sum_in      = '0;
            prev_err_in = '0;
            err_in      = '0;
            lost_in     = 1'b0;
         end
         default: ;
      endcase
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         prev_err_ff  <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         prev_err_ff  <= prev_err_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         bits_ff <= req_sensor_bits;
      end
      err_ff  <= err_in;
      lost_ff <= lost_in;
      acc_ff  <= acc_in;
      if (ctrl.op == OP_MUL_P || ctrl.op == OP_MUL_I || ctrl.op == OP_MUL_D) begin
         prod_ff <= mul_p;
      end
      if (ctrl.op == OP_CORR) begin
         corr_ff <= corr_sum[ACC_W-1:SHIFT_W];
      end
      if (ctrl.op == OP_TARGET) begin
         tl_ff <= base_t - corr_t;
         tr_ff <= base_t + corr_t;
      end
      if (ctrl.op == OP_CLAMP) begin
         cl_ff <= clamp_speed(tl_ff, cfg.max_spd);
         cr_ff <= clamp_speed(tr_ff, cfg.max_spd);
      end
      if (emit_go) begin
         rsp_left_ff  <= left_ff;
         rsp_right_ff <= right_ff;
         rsp_err_ff   <= err_ff;
         rsp_lost_ff  <= lost_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_speed     = rsp_left_ff;
   assign rsp_right_speed    = rsp_right_ff;
   assign rsp_position_error = rsp_err_ff;
   assign rsp_line_lost      = rsp_lost_ff;

endmodule

`default_nettype wire

FILE: sv/line_follow_pid_drive_unit.sv
// Line follower PID drive unit. A step word runs the microcode steps lookup, integrate,
// multiply P, I and D, accumulate, correction, target, clamp, slew and emit; a clear word
// runs lookup, clear and emit. Each word ends in a return step to the wait step, where the
// next word is taken. One datapath step runs per cycle, but emit holds while the last result
// is stalled. Synchronous reset loads the register defaults, zeroes the integral, last error
// and wheel state, and returns the sequencer to its wait step. Depends on lfpd_pkg.
`default_nettype none

module line_follow_pid_drive_unit
   import lfpd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_mode,
   input  wire logic [SENS_W-1:0]        req_sensor_bits,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [SPD_W-1:0]       rsp_left_speed,
   output logic signed [SPD_W-1:0]       rsp_right_speed,
   output logic signed [ERR_W-1:0]       rsp_position_error,
   output logic                          rsp_line_lost,
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   ctrl_type ctrl;
   stat_type stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_KP:    cfg_in.kp      = csr_wdata;
            REG_KI:    cfg_in.ki      = csr_wdata;
            REG_KD:    cfg_in.kd      = csr_wdata;
            REG_BASE:  cfg_in.base    = csr_wdata[BYTE_W-1:0];
            REG_MAX:   cfg_in.max_spd = csr_wdata[BYTE_W-1:0];
            REG_ACCEL: cfg_in.accel   = csr_wdata[BYTE_W-1:0];
            REG_ILIM:  cfg_in.ilim    = csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{kp: KP_RESET, ki: KI_RESET, kd: KD_RESET, base: BASE_RESET,
                     max_spd: MAX_RESET, accel: ACCEL_RESET, ilim: ILIM_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfpd_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   lfpd_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .cfg                (cfg_ff),
      .stat               (stat),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_sensor_bits    (req_sensor_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_speed     (rsp_left_speed),
      .rsp_right_speed    (rsp_right_speed),
      .rsp_position_error (rsp_position_error),
      .rsp_line_lost      (rsp_line_lost)
   );

endmodule

`default_nettype wire

FILE: sv/lfpd_chk.sv
// Port-level checker for the line follower PID drive unit, bound to the top level.
// Depends on lfpd_pkg and line_follow_pid_drive_unit.
`default_nettype none

module lfpd_chk
   import lfpd_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [SPD_W-1:0]  rsp_left_speed,
   input wire logic signed [SPD_W-1:0]  rsp_right_speed,
   input wire logic signed [ERR_W-1:0]  rsp_position_error,
   input wire logic                     rsp_line_lost
);

   // A waiting result word keeps its contents until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_speed)
         && $stable(rsp_right_speed) && $stable(rsp_position_error)
         && $stable(rsp_line_lost))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One word is in work at a time: after an acceptance the input is stalled.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while one is in work");

   // Wheel speeds never reach the most negative code of their width.
   a_speed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed != 9'sh100) && (rsp_right_speed != 9'sh100))
      else $error("wheel speed out of range");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_stall)
      else $error("result appeared while the unit was waiting for input");

endmodule

bind line_follow_pid_drive_unit lfpd_chk u_lfpd_chk (.*);

`default_nettype wire

FILE: sim/line_follow_pid_drive_unit_tb.sv
// Self-checking bench for the line follower PID drive unit: a predictor of the drive step
// checks every result word in order while the sender bursts and the receiver stalls at random.
// Depends on lfpd_pkg and line_follow_pid_drive_unit.
`default_nettype none

module line_follow_pid_drive_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lfpd_pkg::*;

   localparam logic MODE_STEP  = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1000000;

   typedef struct {
      logic signed [SPD_W-1:0] left;
      logic signed [SPD_W-1:0] right;
      logic signed [ERR_W-1:0] err;
      logic                    lost;
   } wheel_word_type;

   class drive_scoreboard_type;
      longint kp_gain, ki_gain, kd_gain;
      longint nominal_spd, speed_cap, slew_cap, integral_limit;
      longint integ, last_err, last_left, last_right;
      wheel_word_type expected_q[$];
      int fails;

      function new();
         kp_gain = KP_RESET;
         ki_gain = KI_RESET;
         kd_gain = KD_RESET;
         nominal_spd = BASE_RESET;
         speed_cap = MAX_RESET;
         slew_cap = ACCEL_RESET;
         integral_limit = ILIM_RESET;
         integ = 0;
         last_err = 0;
         last_left = 0;
         last_right = 0;
         fails = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(input string what);
         $display("mismatch at %0t ns: %s", $time, what);
         fails++;
      endtask

      function longint clip(input longint x, input longint lo, input longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      // Magnitude clamp first, then the slew limit around the previous speed.
      function longint wheel_step(input longint target, input longint prior);
         longint s;
         s = clip(target, -speed_cap, speed_cap);
         return clip(s, prior - slew_cap, prior + slew_cap);
      endfunction

      function void set_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_KP:    kp_gain = data;
            REG_KI:    ki_gain = data;
            REG_KD:    kd_gain = data;
            REG_BASE:  nominal_spd = data[BYTE_W-1:0];
            REG_MAX:   speed_cap = data[BYTE_W-1:0];
            REG_ACCEL: slew_cap = data[BYTE_W-1:0];
            REG_ILIM:  integral_limit = data[BYTE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(input logic mode, input logic [SENS_W-1:0] bits);
         wheel_word_type w;
         longint wsum, cnt, err, lim, total, corr;
         int i;
         if (mode == MODE_CLEAR) begin
            integ = 0;
            last_err = 0;
            w.left = last_left[SPD_W-1:0];
            w.right = last_right[SPD_W-1:0];
            w.err = '0;
            w.lost = 1'b0;
         end else begin
            wsum = 0;
            cnt = 0;
            for (i = 0; i < SENS_W; i++) begin
               if (bits[i]) begin
                  wsum += (i == 0) ? -3 : (i == 1) ? -2 : (i == 3) ? 2 : (i == 4) ? 3 : 0;
                  cnt++;
               end
            end
            // A blank sensor row holds the last error, so the derivative term vanishes.
            if (cnt == 0)
               err = last_err;
            else
               err = (wsum * (longint'(1) <<< FRAC_BITS)) / cnt;
            lim = integral_limit * (longint'(1) <<< FRAC_BITS);
            integ = clip(integ + err, -lim, lim);
            total = kp_gain * err + ki_gain * integ + kd_gain * (err - last_err);
            corr = total / (longint'(1) <<< SHIFT_W);
            last_err = err;
            last_left = wheel_step(nominal_spd - corr, last_left);
            last_right = wheel_step(nominal_spd + corr, last_right);
            w.left = last_left[SPD_W-1:0];
            w.right = last_right[SPD_W-1:0];
            w.err = err[ERR_W-1:0];
            w.lost = (cnt == 0);
         end
         expected_q.push_back(w);
      endfunction

      task check_response(input logic signed [SPD_W-1:0] left,
                          input logic signed [SPD_W-1:0] right,
                          input logic signed [ERR_W-1:0] err,
                          input logic lost);
         wheel_word_type w;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected word left=%0d right=%0d err=%0d lost=%0b",
                             left, right, err, lost));
         end else begin
            w = expected_q.pop_front();
            if (left !== w.left)
               report($sformatf("left_speed %0d, expected %0d", left, w.left));
            if (right !== w.right)
               report($sformatf("right_speed %0d, expected %0d", right, w.right));
            if (err !== w.err)
               report($sformatf("position_error %0d, expected %0d", err, w.err));
            if (lost !== w.lost)
               report($sformatf("line_lost %0b, expected %0b", lost, w.lost));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_mode = 1'b0;
   logic [SENS_W-1:0]        req_sensor_bits = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [SPD_W-1:0]  rsp_left_speed;
   logic signed [SPD_W-1:0]  rsp_right_speed;
   logic signed [ERR_W-1:0]  rsp_position_error;
   logic                     rsp_line_lost;
   logic                     csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   logic [CSR_DATA_W-1:0]    setting [7];
   drive_scoreboard_type     sb = new();

   line_follow_pid_drive_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_sensor_bits    (req_sensor_bits),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_speed     (rsp_left_speed),
      .rsp_right_speed    (rsp_right_speed),
      .rsp_position_error (rsp_position_error),
      .rsp_line_lost      (rsp_line_lost),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [CSR_DATA_W-1:0] rand_word(input int unsigned hi);
      return CSR_DATA_W'($urandom_range(0, hi));
   endfunction

   // Register writes and accepted words are both taken at the edge, as the block sees them.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.set_register(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            sb.note_request(req_mode, req_sensor_bits);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_left_speed, rsp_right_speed, rsp_position_error,
                              rsp_line_lost);
      end
   end

   // The receiver alternates between free flow, light and heavy stalling, and long holds.
   initial begin : stall_pattern
      int style;
      int span;
      forever begin
         style = $urandom_range(0, 3);
         span = $urandom_range(5, 80);
         repeat (span) begin
            @(posedge clock);
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 30);
               2: rsp_stall <= ($urandom_range(0, 99) < 75);
               default: rsp_stall <= (span < 40);
            endcase
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_word(input logic mode, input logic [SENS_W-1:0] bits);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sensor_bits <= bits;
      do @(posedge clock); while (req_stall);
   endtask

   // The first edge lets the monitor record the last accepted word before the count is read.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_settings(input bit stray);
      int idx;
      for (idx = REG_KP; idx <= REG_ILIM; idx++) begin
         csr_we <= 1'b1;
         csr_index <= idx[CSR_IDX_W-1:0];
         csr_wdata <= setting[idx];
         @(posedge clock);
      end
      if (stray) begin
         csr_index <= REG_UNUSED;
         csr_wdata <= rand_word(65535);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random(input int count);
      int n;
      int burst;
      int gap;
      logic mode;
      logic [SENS_W-1:0] held;
      held = 5'b00100;
      burst = $urandom_range(1, 30);
      for (n = 0; n < count; n++) begin
         mode = ($urandom_range(0, 99) < 6) ? MODE_CLEAR : MODE_STEP;
         case ($urandom_range(0, 7))
            0: held = '0;
            1, 2, 3: ;
            default: held = SENS_W'($urandom_range(0, 31));
         endcase
         send_word(mode, held);
         burst--;
         if (burst == 0) begin
            if ($urandom_range(0, 11) == 0) begin
               wait_drained();
            end else begin
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            // Now and then a long burst with no gaps at all.
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
         end
      end
   endtask

   initial begin : stimulus
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset settings: sensor extremes, truncated thirds,
      // a blank row held twice, a clear followed by a blank row, and a steady saturating run.
      send_word(MODE_STEP, 5'b00100);
      send_word(MODE_STEP, 5'b00001);
      send_word(MODE_STEP, 5'b10000);
      send_word(MODE_STEP, 5'b00011);
      send_word(MODE_STEP, 5'b11000);
      send_word(MODE_STEP, 5'b00111);
      send_word(MODE_STEP, 5'b11100);
      send_word(MODE_STEP, 5'b01101);
      send_word(MODE_STEP, 5'b10110);
      send_word(MODE_STEP, 5'b00000);
      send_word(MODE_STEP, 5'b00000);
      send_word(MODE_STEP, 5'b11111);
      send_word(MODE_STEP, 5'b01010);
      send_word(MODE_CLEAR, 5'b11111);
      send_word(MODE_STEP, 5'b00000);
      send_word(MODE_STEP, 5'b10001);
      repeat (6) send_word(MODE_STEP, 5'b00001);
      send_word(MODE_CLEAR, 5'b00000);

      for (phase = 0; phase < 9; phase++) begin
         wait_drained();
         case (phase)
            0: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'd255, 16'd255};
            // Lower max speed right after the fast phase, with a slow slew.
            1: setting = '{16'd17920, 16'd13, 16'd0, 16'd200, 16'd60, 16'd5, 16'd50};
            2: setting = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            3: setting = '{16'd17920, 16'd13, 16'd2000, 16'd100, 16'd255, 16'd255, 16'd50};
            4: setting = '{rand_word(65535), rand_word(65535), rand_word(65535),
                           rand_word(65535), rand_word(65535), rand_word(65535),
                           rand_word(65535)};
            default: setting = '{rand_word(40000), rand_word(2000), rand_word(20000),
                                 rand_word(255), rand_word(255), rand_word(255),
                                 rand_word(255)};
         endcase
         program_settings(phase == 4);
         run_random(200);
      end

      wait_drained();
      repeat (24) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected words never arrived", sb.pending()));
      if (sb.fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
